[sv/ese_pkg.sv]
// Shared types and constants of the encoder speed estimator.
`timescale 1ns / 1ps

package ese_pkg;

   // Fixed field widths
   localparam int TOTAL_W   = 32;
   localparam int DELTA_W   = 17;
   localparam int SPEED_W   = 24;
   localparam int RELOAD_W  = 17;
   localparam int THRESH_W  = 16;
   localparam int SCALE_W   = 24;
   localparam int FRAC_BITS = 16;

   // Configuration port
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_RELOAD    = 2'd0;
   localparam csr_index_type CSR_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_SCALE     = 2'd2;

   // Register values after reset
   localparam logic [RELOAD_W-1:0] RELOAD_RESET    = 17'd20000;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd19000;
   localparam logic [SCALE_W-1:0]  SCALE_RESET     = 24'd65536;

   // Saturation limits
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 17'sh0FFFF;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = 17'sh10000;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;

endpackage

[sv/encoder_speed_estimator.sv]
// Encoder count extension, moving-average delta filter and speed scaling.
`timescale 1ns / 1ps

// Takes one encoder sample per beat (counter reading and direction) and
// returns one result per beat: the wrap-extended 32-bit count, the direction
// and a speed equal to the rounded average of the last WINDOW_LEN count
// deltas times speed_scale (Q16), saturated to 24 bits. A new sample can be
// taken every clock cycle while a stalled result does not hold up the input
// and no product rebuild is pending; each pipeline stage moves on
// independently, so a stalled result only holds up the stages behind it once
// they are full. The count extension uses a kept product of base offset and
// reload value that is stepped by one reload per wrap; after a write to
// reload_value the input is stalled while that product is rebuilt on the single 32x17 multiplier.
module encoder_speed_estimator #(
   parameter int WINDOW_LEN   = 8,
   parameter int COUNTER_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [COUNTER_BITS-1:0]                req_counter_value,
   input  logic                                   req_count_down,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ese_pkg::SPEED_W-1:0]     rsp_filtered_speed,
   output logic                                   rsp_direction,
   output logic signed [ese_pkg::TOTAL_W-1:0]     rsp_extended_count,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  ese_pkg::csr_index_type                 csr_index,
   input  logic [ese_pkg::CSR_DATA_W-1:0]         csr_data
);

   import ese_pkg::*;

   // Derived sizes
   localparam int LOG2_W   = $clog2(WINDOW_LEN);
   localparam int SUM_W    = DELTA_W + LOG2_W;
   localparam int PROD_W   = SUM_W + SCALE_W + 1;
   localparam int HALF     = WINDOW_LEN * (2 ** (FRAC_BITS - 1));
   localparam int MCAP     = WINDOW_LEN * ((2 ** (SPEED_W - 1)) + 1);
   localparam int M_W      = $clog2(MCAP + 1);
   localparam int Q_W      = SPEED_W;
   localparam bit IS_POW2  = (WINDOW_LEN & (WINDOW_LEN - 1)) == 0;

   // Configuration registers
   logic [RELOAD_W-1:0] reload_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic                rebuild_ff;

   // Count and window state
   logic [TOTAL_W-1:0]        last_total_ff;
   logic [TOTAL_W-1:0]        base_offset_ff;
   logic [TOTAL_W-1:0]        offset_prod_ff;
   logic signed [DELTA_W-1:0] window_ff [WINDOW_LEN];
   logic signed [SUM_W-1:0]   sum_ff;

   // Pipeline stages
   logic                      s1_valid_ff;
   logic [COUNTER_BITS-1:0]   s1_counter_ff;
   logic                      s1_down_ff;

   logic                      s2_valid_ff;
   logic signed [SUM_W-1:0]   s2_sum_ff;
   logic [TOTAL_W-1:0]        s2_total_ff;
   logic                      s2_down_ff;

   logic                      s3_valid_ff;
   logic signed [PROD_W-1:0]  s3_prod_ff;
   logic [TOTAL_W-1:0]        s3_total_ff;
   logic                      s3_down_ff;

   logic                      s4_valid_ff;
   logic [M_W-1:0]            s4_mag_ff;
   logic                      s4_neg_ff;
   logic [TOTAL_W-1:0]        s4_total_ff;
   logic                      s4_down_ff;

   logic                      s5_valid_ff;
   logic [Q_W-1:0]            s5_quot_ff;
   logic                      s5_neg_ff;
   logic [TOTAL_W-1:0]        s5_total_ff;
   logic                      s5_down_ff;

   logic                      out_valid_ff;
   logic signed [SPEED_W-1:0] out_speed_ff;
   logic                      out_down_ff;
   logic [TOTAL_W-1:0]        out_total_ff;

   // Stage can take new contents
   logic free1, free2, free3, free4, free5, free6;
   logic take_in;

   assign free6 = !out_valid_ff || !rsp_stall;
   assign free5 = !s5_valid_ff || free6;
   assign free4 = !s4_valid_ff || free5;
   assign free3 = !s3_valid_ff || free4;
   assign free2 = !s2_valid_ff || free3;
   assign free1 = !s1_valid_ff || free2;

   assign req_stall = !free1 || rebuild_ff;
   assign take_in   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes; a new reload value asks for a product rebuild
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= RELOAD_RESET;
         threshold_ff <= THRESHOLD_RESET;
         scale_ff     <= SCALE_RESET;
         rebuild_ff   <= 1'b0;
      end else begin
         rebuild_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RELOAD: begin
                  reload_ff  <= csr_data[RELOAD_W-1:0];
                  rebuild_ff <= 1'b1;
               end
               CSR_THRESHOLD: threshold_ff <= csr_data[THRESH_W-1:0];
               CSR_SCALE:     scale_ff     <= csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (free1) begin
         s1_valid_ff <= take_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_counter_ff <= req_counter_value;
         s1_down_ff    <= req_count_down;
      end
   end

   // Count extension, wrap detection and delta
   logic [TOTAL_W-1:0]        reload_ext, thresh_ext;
   logic [TOTAL_W-1:0]        total0, back_jump, fwd_jump;
   logic [TOTAL_W-1:0]        total_in, jump;
   logic                      wrap_up, wrap_down;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]   sum_in;
   logic                      step;

   always_comb begin
      reload_ext = TOTAL_W'(reload_ff);
      thresh_ext = TOTAL_W'(threshold_ff);
      total0     = TOTAL_W'(s1_counter_ff) + offset_prod_ff;
      back_jump  = last_total_ff - total0;
      fwd_jump   = total0 - last_total_ff;
      wrap_up    = $signed(back_jump) > $signed(thresh_ext);
      wrap_down  = !wrap_up && ($signed(fwd_jump) > $signed(thresh_ext));

      if (wrap_up) begin
         total_in = total0 + reload_ext;
         jump     = fwd_jump + reload_ext;
      end else if (wrap_down) begin
         total_in = total0 - reload_ext;
         jump     = fwd_jump - reload_ext;
      end else begin
         total_in = total0;
         jump     = fwd_jump;
      end

      // saturate to the delta range
      if (jump[TOTAL_W-1:DELTA_W-1] == '0 || jump[TOTAL_W-1:DELTA_W-1] == '1) begin
         delta = $signed(jump[DELTA_W-1:0]);
      end else if (jump[TOTAL_W-1]) begin
         delta = DELTA_MIN;
      end else begin
         delta = DELTA_MAX;
      end

      sum_in = sum_ff - SUM_W'(window_ff[WINDOW_LEN-1]) + SUM_W'(delta);
      step   = s1_valid_ff && free2;
   end

   // State update as a sample leaves the input register, or product rebuild after a reload write
   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff  <= '0;
         base_offset_ff <= '0;
         offset_prod_ff <= '0;
         sum_ff         <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else if (rebuild_ff) begin
         offset_prod_ff <= TOTAL_W'(base_offset_ff * reload_ext);
      end else if (step) begin
         last_total_ff <= total_in;
         sum_ff        <= sum_in;
         if (wrap_up) begin
            base_offset_ff <= base_offset_ff + TOTAL_W'(1);
            offset_prod_ff <= offset_prod_ff + reload_ext;
         end else if (wrap_down) begin
            base_offset_ff <= base_offset_ff - TOTAL_W'(1);
            offset_prod_ff <= offset_prod_ff - reload_ext;
         end
         // oldest delta sits at the tail of the shift line
         window_ff[0] <= delta;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   // Stage 2: window sum and total
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (free2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s2_sum_ff   <= sum_in;
         s2_total_ff <= total_in;
         s2_down_ff  <= s1_down_ff;
      end
   end

   // Stage 3: scale multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (free3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && free3) begin
         s3_prod_ff  <= PROD_W'(s2_sum_ff) * $signed(PROD_W'(scale_ff));
         s3_total_ff <= s2_total_ff;
         s3_down_ff  <= s2_down_ff;
      end
   end

   // Stage 4: magnitude, rounding offset, drop fraction bits, clamp
   logic [PROD_W-1:0] prod_mag;
   logic [PROD_W:0]   rounded;
   logic [M_W-1:0]    mag_in;

   always_comb begin
      prod_mag = s3_prod_ff[PROD_W-1] ? PROD_W'(-s3_prod_ff) : PROD_W'(s3_prod_ff);
      rounded  = ((PROD_W + 1)'(prod_mag) + (PROD_W + 1)'(HALF)) >> FRAC_BITS;
      if (rounded > (PROD_W + 1)'(MCAP)) begin
         mag_in = M_W'(MCAP);
      end else begin
         mag_in = rounded[M_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (free4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && free4) begin
         s4_mag_ff   <= mag_in;
         s4_neg_ff   <= s3_prod_ff[PROD_W-1];
         s4_total_ff <= s3_total_ff;
         s4_down_ff  <= s3_down_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (free5) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid_ff && free5) begin
         s5_neg_ff   <= s4_neg_ff;
         s5_total_ff <= s4_total_ff;
         s5_down_ff  <= s4_down_ff;
      end
   end

   // Stages 5 and 6: divide by the window length
   logic quot_fix;

   generate
      if (IS_POW2) begin : g_div_shift
         // plain shift, no correction needed
         always_ff @(posedge clock) begin
            if (s4_valid_ff && free5) begin
               s5_quot_ff <= Q_W'(s4_mag_ff >> LOG2_W);
            end
         end
         assign quot_fix = 1'b0;
      end else begin : g_div_recip
         // reciprocal estimate is exact or one short
         localparam logic [TOTAL_W-1:0] RECIP = TOTAL_W'((64'd1 << TOTAL_W) / WINDOW_LEN);
         logic [M_W+TOTAL_W-1:0] recip_prod;
         logic [M_W-1:0]         s5_mag_ff;
         logic [M_W-1:0]         remain;

         assign recip_prod = (M_W + TOTAL_W)'(s4_mag_ff) * (M_W + TOTAL_W)'(RECIP);

         always_ff @(posedge clock) begin
            if (s4_valid_ff && free5) begin
               s5_quot_ff <= Q_W'(recip_prod >> TOTAL_W);
               s5_mag_ff  <= s4_mag_ff;
            end
         end

         assign remain   = s5_mag_ff - M_W'(s5_quot_ff) * M_W'(WINDOW_LEN);
         assign quot_fix = remain >= M_W'(WINDOW_LEN);
      end
   endgenerate

   // Sign and saturation to 24 bits
   logic [Q_W-1:0]            quot;
   logic signed [SPEED_W-1:0] speed_in;

   always_comb begin
      quot = s5_quot_ff + Q_W'(quot_fix);
      if (s5_neg_ff) begin
         speed_in = quot[Q_W-1] ? SPEED_MIN : -$signed(quot);
      end else begin
         speed_in = quot[Q_W-1] ? SPEED_MAX : $signed(quot);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (free6) begin
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_valid_ff && free6) begin
         out_speed_ff <= speed_in;
         out_down_ff  <= s5_down_ff;
         out_total_ff <= s5_total_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_filtered_speed = out_speed_ff;
   assign rsp_direction      = out_down_ff;
   assign rsp_extended_count = $signed(out_total_ff);

endmodule

[sim/speed_checker.sv]
// Watches the sample, result and register channels of the speed estimator and checks each result.
`timescale 1ns / 1ps

module speed_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [15:0]                         req_counter_value,
   input  logic                                req_count_down,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [ese_pkg::SPEED_W-1:0]  rsp_filtered_speed,
   input  logic                                rsp_direction,
   input  logic signed [ese_pkg::TOTAL_W-1:0]  rsp_extended_count,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  ese_pkg::csr_index_type              csr_index,
   input  logic [ese_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                  mismatches,
   output int                                  outstanding
);

   import ese_pkg::*;

   localparam int     WINDOW      = 8;
   localparam longint AVG_DIVISOR = longint'(WINDOW) << FRAC_BITS;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic                      direction;
      logic signed [TOTAL_W-1:0] count;
   } speed_result_type;

   // Register copies
   logic [RELOAD_W-1:0]   reload_reg;
   logic [THRESH_W-1:0]   threshold_reg;
   logic [SCALE_W-1:0]    scale_reg;

   // Estimator state
   logic [TOTAL_W-1:0]        last_total;
   logic [TOTAL_W-1:0]        base_offset;
   logic signed [DELTA_W-1:0] deltas [WINDOW];
   longint                    window_sum;
   int                        slot;

   speed_result_type expected_speeds[$];

   task automatic clear_estimator();
      reload_reg    = RELOAD_RESET;
      threshold_reg = THRESHOLD_RESET;
      scale_reg     = SCALE_RESET;
      last_total    = '0;
      base_offset   = '0;
      for (int i = 0; i < WINDOW; i++) deltas[i] = '0;
      window_sum    = 0;
      slot          = 0;
   endtask

   // One tick: extend the count, update the window, scale and round the average
   function automatic speed_result_type estimate_speed(input logic [15:0] reading,
                                                       input logic down);
      logic [TOTAL_W-1:0] total;
      int                 jump;
      longint             step;
      longint             prod;
      longint             mag;
      longint             spd;
      logic               neg;
      speed_result_type   r;
      total = {16'd0, reading} + base_offset * {15'd0, reload_reg};
      // a backward jump beyond the threshold means the counter wrapped forwards
      jump = last_total - total;
      if (jump > int'({16'd0, threshold_reg})) begin
         base_offset = base_offset + TOTAL_W'(1);
         total = {16'd0, reading} + base_offset * {15'd0, reload_reg};
      end else begin
         jump = total - last_total;
         if (jump > int'({16'd0, threshold_reg})) begin
            base_offset = base_offset - TOTAL_W'(1);
            total = {16'd0, reading} + base_offset * {15'd0, reload_reg};
         end
      end
      // delta saturated to the window's width
      jump = total - last_total;
      step = longint'(jump);
      if (step > longint'(DELTA_MAX)) step = longint'(DELTA_MAX);
      if (step < longint'(DELTA_MIN)) step = longint'(DELTA_MIN);
      window_sum   = window_sum - longint'(deltas[slot]) + step;
      deltas[slot] = step[DELTA_W-1:0];
      slot         = (slot + 1) % WINDOW;
      // rounding to nearest, ties away from zero
      prod = window_sum * longint'({1'b0, scale_reg});
      neg  = prod < 0;
      mag  = neg ? -prod : prod;
      mag  = (mag + AVG_DIVISOR / 2) / AVG_DIVISOR;
      if (neg) begin
         spd = -mag;
         if (spd < longint'(SPEED_MIN)) spd = longint'(SPEED_MIN);
      end else begin
         spd = mag;
         if (spd > longint'(SPEED_MAX)) spd = longint'(SPEED_MAX);
      end
      last_total  = total;
      r.speed     = spd[SPEED_W-1:0];
      r.direction = down;
      r.count     = total;
      return r;
   endfunction

   // Results are checked before the same edge's sample is predicted
   always @(posedge clock) begin
      speed_result_type want;
      if (reset) begin
         clear_estimator();
         expected_speeds.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_speeds.size() == 0) begin
               $error("result beat with no sample outstanding");
               mismatches++;
            end else begin
               want = expected_speeds.pop_front();
               if (rsp_filtered_speed !== want.speed) begin
                  $error("filtered_speed: expected %0d, got %0d",
                         want.speed, rsp_filtered_speed);
                  mismatches++;
               end
               if (rsp_direction !== want.direction) begin
                  $error("direction: expected %0d, got %0d", want.direction, rsp_direction);
                  mismatches++;
               end
               if (rsp_extended_count !== want.count) begin
                  $error("extended_count: expected %0d, got %0d",
                         want.count, rsp_extended_count);
                  mismatches++;
               end
            end
         end
         // register writes, masked to width; the spare index is ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RELOAD:    reload_reg    = csr_data[RELOAD_W-1:0];
               CSR_THRESHOLD: threshold_reg = csr_data[THRESH_W-1:0];
               CSR_SCALE:     scale_reg     = csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_speeds.push_back(estimate_speed(req_counter_value, req_count_down));
      end
      outstanding <= expected_speeds.size();
   end

endmodule

[sim/testbench.sv]
// Stimulus and verdict for the encoder speed estimator.
`timescale 1ns / 1ps

module testbench;

   import ese_pkg::*;

   localparam csr_index_type CSR_SPARE = 2'd3;   // no register behind this index
   localparam int MAX_GAP      = 19;
   localparam int SETTLE       = 8;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 107;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [15:0]                 req_counter_value = '0;
   logic                        req_count_down = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [SPEED_W-1:0]   rsp_filtered_speed;
   logic                        rsp_direction;
   logic signed [TOTAL_W-1:0]   rsp_extended_count;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_RELOAD;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   int   mismatches;
   int   outstanding;
   logic calm = 1'b0;   // both sides run without gaps while set

   // Encoder motion used to build well-formed sample sequences
   int   enc_pos  = 0;
   int   enc_span = 20000;
   logic enc_down = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   encoder_speed_estimator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_counter_value  (req_counter_value),
      .req_count_down     (req_count_down),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_speed (rsp_filtered_speed),
      .rsp_direction      (rsp_direction),
      .rsp_extended_count (rsp_extended_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   speed_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_counter_value  (req_counter_value),
      .req_count_down     (req_count_down),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_speed (rsp_filtered_speed),
      .rsp_direction      (rsp_direction),
      .rsp_extended_count (rsp_extended_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // Counter modulus the encoder really runs with
   function automatic int span_of(input logic [CSR_DATA_W-1:0] reload);
      int eff;
      eff = int'(reload[RELOAD_W-1:0]);
      return (eff == 0 || eff > 65536) ? 65536 : eff;
   endfunction

   // Sample beat after a random gap
   task automatic send_sample(input logic [15:0] reading, input logic down);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_counter_value <= reading;
      req_count_down    <= down;
      do @(posedge clock); while (req_stall);
   endtask

   // Leaves csr_valid high so that writes can follow back to back
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Hold off the sender until every result is back and the pipeline is empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] reload,
                            input logic [CSR_DATA_W-1:0] thr,
                            input logic [CSR_DATA_W-1:0] scale);
      drain();
      write_reg(CSR_RELOAD, reload);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_SCALE, scale);
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 24'hFFFFFF)));
      csr_valid <= 1'b0;
      enc_span = span_of(reload);
      enc_pos  = enc_pos % enc_span;
   endtask

   task automatic configure_random();
      logic [CSR_DATA_W-1:0] reload;
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] scale;
      case ($urandom_range(0, 4))
         0:       reload = '0;
         1:       reload = CSR_DATA_W'(65536);
         2:       reload = CSR_DATA_W'($urandom_range(1, 65536));
         3:       reload = CSR_DATA_W'($urandom_range(1, 2000));
         default: reload = CSR_DATA_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      case ($urandom_range(0, 3))
         0:       thr = CSR_DATA_W'($urandom_range(0, 65535));
         1:       thr = CSR_DATA_W'($urandom_range(0, 24'hFFFFFF));
         default: thr = CSR_DATA_W'((span_of(reload) * 19) / 20);
      endcase
      case ($urandom_range(0, 2))
         0:       scale = CSR_DATA_W'($urandom_range(0, 24'hFFFFFF));
         1:       scale = CSR_DATA_W'($urandom_range(0, 255));
         default: scale = CSR_DATA_W'($urandom_range(32768, 262144));
      endcase
      configure(reload, thr, scale);
   endtask

   // Next reading of an encoder turning with random speed, wrapping at the modulus
   task automatic move_encoder(output logic [15:0] reading, output logic down);
      int stride;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: stride = $urandom_range(0, 64);
         6, 7:             stride = $urandom_range(0, 4000);
         8:                stride = $urandom_range(0, 30000);
         default:          stride = $urandom_range(0, 65535);
      endcase
      if ($urandom_range(0, 15) == 0) enc_down = !enc_down;
      enc_pos = enc_down ? enc_pos - stride : enc_pos + stride;
      enc_pos = ((enc_pos % enc_span) + enc_span) % enc_span;
      reading = enc_pos[15:0];
      down    = enc_down;
   endtask

   // Mostly encoder motion, some raw noise, calm stretches and full drains
   task automatic run_phase(input int beats);
      logic [15:0] reading;
      logic        down;
      for (int i = 0; i < beats; i++) begin
         if (i % 32 == 0) calm = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 79) == 0) drain();
         if ($urandom_range(0, 4) == 0) begin
            reading = 16'($urandom_range(0, 65535));
            down    = 1'($urandom_range(0, 1));
         end else begin
            move_encoder(reading, down);
         end
         send_sample(reading, down);
      end
   endtask

   // Result side stalls for a random number of cycles before each beat
   initial begin
      int gap;
      forever begin
         gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: small moves, forward and backward wraps, counter extremes
      send_sample(16'd0, 1'b0);
      send_sample(16'd100, 1'b0);
      send_sample(16'd19000, 1'b0);
      send_sample(16'd19999, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd65535, 1'b1);
      send_sample(16'd0, 1'b1);
      send_sample(16'd65535, 1'b0);
      send_sample(16'd1234, 1'b1);
      send_sample(16'd1230, 1'b1);
      send_sample(16'd1230, 1'b0);
      send_sample(16'd1234, 1'b0);
      send_sample(16'h5555, 1'b1);
      send_sample(16'hAAAA, 1'b0);
      run_phase(PHASE_BEATS);

      for (int p = 1; p < PHASES; p++) begin
         case (p)
            1: begin
               // zero reload, zero threshold, full scale: every jump moves the offset
               configure(24'd0, 24'd0, 24'hFFFFFF);
               send_sample(16'd0, 1'b0);
               send_sample(16'd65535, 1'b0);
               send_sample(16'd0, 1'b1);
               send_sample(16'd65535, 1'b0);
               send_sample(16'd65535, 1'b0);
               send_sample(16'd0, 1'b1);
               send_sample(16'd0, 1'b1);
               send_sample(16'd0, 1'b1);
               send_sample(16'd65535, 1'b0);
               send_sample(16'd1, 1'b1);
            end
            // widest reload and threshold after masking, zero scale
            2: configure(24'hFFFFFF, 24'hFFFFFF, 24'd0);
            // jumps survive the correction
            3: configure(24'd65536, 24'd0, 24'd1);
            default: configure_random();
         endcase
         run_phase(PHASE_BEATS);
      end

      drain();
      if (mismatches == 0 && outstanding == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Run limit
   initial begin
      #1_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
